// ===== rtl/rtcc_pkg.sv =====
// Package for the RTC time register codec: transaction types, codes and
// small arithmetic helpers. No dependencies.
package rtcc_pkg;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

  typedef enum logic {
    CFG_WEEK_ONEHOT = 1'b0,
    CFG_HOUR_FLAG   = 1'b1
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 1;

  typedef struct packed {
    op_e        operation;
    logic [7:0] in_second;
    logic [7:0] in_minute;
    logic [7:0] in_hour;
    logic [7:0] in_weekday;
    logic [7:0] in_day;
    logic [7:0] in_month;
    logic [7:0] in_year;
  } rtcc_in_t;

  typedef struct packed {
    logic [7:0] out_second;
    logic [7:0] out_minute;
    logic [7:0] out_hour;
    logic [7:0] out_weekday;
    logic [7:0] out_day;
    logic [7:0] out_month;
    logic [7:0] out_year;
  } rtcc_out_t;

  // Positions of the six BCD-coded fields inside the pipeline arrays.
  localparam int unsigned NumBcd  = 6;
  localparam int unsigned F_SEC   = 0;
  localparam int unsigned F_MIN   = 1;
  localparam int unsigned F_HOUR  = 2;
  localparam int unsigned F_DAY   = 3;
  localparam int unsigned F_MONTH = 4;
  localparam int unsigned F_YEAR  = 5;

  // Decode register masks.
  localparam logic [7:0] MaskSecMin  = 8'h7F;
  localparam logic [7:0] MaskHourDay = 8'h3F;
  localparam logic [7:0] MaskMonth   = 8'h1F;
  localparam logic [7:0] MaskYear    = 8'hFF;

  localparam logic [7:0]  HourFlagBit = 8'h80;
  localparam logic [11:0] YearBase    = 12'd2000;
  localparam logic [2:0]  Saturday    = 3'd6;

  // Tens nibble times ten plus units nibble; nibbles above nine are taken as is.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'b0, b[7:4]};
    return (tens << 3) + (tens << 1) + {4'b0, b[3:0]};
  endfunction

  // Quotient by ten through the reciprocal 205/2048, exact for all 8-bit values.
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd205;
    return p[15:11];
  endfunction

endpackage

// ===== rtl/rtc_time_register_codec.sv =====
// Top level of the RTC time register codec: a three-stage pipeline that
// converts a seven-byte BCD register image to binary time and back.
// Depends on rtcc_pkg.

// The block takes one transaction per clock cycle on the input channel
// whenever in_ready_o is high, which a stalled output side can hold low; the
// three register stages (BCD unpack and divide-by-ten, BCD pack and Zeller
// month/year terms, Zeller sum with modulo-seven fold) lie between acceptance
// and result; a stalled output holds the pipeline without losing or repeating
// anything. Operation DECODE masks each register byte, unpacks BCD and reads
// the weekday register as one-hot or three-bit binary; when the weekday
// register holds no valid code, the weekday is computed by Zeller's
// congruence for year 2000+yy. Operation ENCODE packs binary fields into BCD,
// computes the weekday by Zeller and encodes it in the selected form; the hour
// flag option sets bit 7 of the hour byte. Configuration writes take effect at
// once and must only be issued while no transaction is in flight.
module rtc_time_register_codec (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  rtcc_pkg::cfg_reg_e           cfg_idx_i,
  input  logic [rtcc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rtcc_pkg::rtcc_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rtcc_pkg::rtcc_out_t          out_data_o
);
  import rtcc_pkg::*;

  // Configuration registers.
  logic week_onehot_q, hour_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      week_onehot_q <= 1'b0;
      hour_flag_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WEEK_ONEHOT: week_onehot_q <= cfg_wdata_i[0];
        CFG_HOUR_FLAG:   hour_flag_q   <= cfg_wdata_i[0];
        default:         ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic en1, en2, en3;

  assign en3        = !s3_valid_q || out_ready_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: mask and unpack BCD for decode, divide by ten for encode, and
  // check the weekday register.
  // ---------------------------------------------------------------------
  logic [7:0] raw   [NumBcd];
  logic [7:0] mask  [NumBcd];
  logic [7:0] s1_val_d [NumBcd];
  logic [4:0] s1_quo_d [NumBcd];
  logic       s1_wk_ok_d;
  logic [2:0] s1_wk_idx_d;

  logic [7:0] s1_val_q [NumBcd];
  logic [4:0] s1_quo_q [NumBcd];
  op_e        s1_op_q;
  logic       s1_wk_ok_q;
  logic [2:0] s1_wk_idx_q;

  logic [6:0] wk_bits;

  always_comb begin
    raw[F_SEC]    = in_data_i.in_second;
    raw[F_MIN]    = in_data_i.in_minute;
    raw[F_HOUR]   = in_data_i.in_hour;
    raw[F_DAY]    = in_data_i.in_day;
    raw[F_MONTH]  = in_data_i.in_month;
    raw[F_YEAR]   = in_data_i.in_year;
    mask[F_SEC]   = MaskSecMin;
    mask[F_MIN]   = MaskSecMin;
    mask[F_HOUR]  = MaskHourDay;
    mask[F_DAY]   = MaskHourDay;
    mask[F_MONTH] = MaskMonth;
    mask[F_YEAR]  = MaskYear;
    for (int i = 0; i < NumBcd; i++) begin
      s1_val_d[i] = (in_data_i.operation == OP_DECODE) ? bcd_to_bin(raw[i] & mask[i])
                                                       : raw[i];
      s1_quo_d[i] = div10(raw[i]);
    end
  end

  // The one-hot form needs exactly one of bits 0 to 6; the binary form
  // rejects only the code seven.
  assign wk_bits = in_data_i.in_weekday[6:0];

  always_comb begin
    s1_wk_idx_d = '0;
    s1_wk_ok_d  = 1'b0;
    if (week_onehot_q) begin
      s1_wk_ok_d = (wk_bits != 7'd0) && ((wk_bits & (wk_bits - 7'd1)) == 7'd0);
      for (int i = 0; i < 7; i++) begin
        if (wk_bits[i]) s1_wk_idx_d = s1_wk_idx_d | 3'(i);
      end
    end else begin
      s1_wk_idx_d = in_data_i.in_weekday[2:0];
      s1_wk_ok_d  = (in_data_i.in_weekday[2:0] != 3'd7);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_op_q     <= in_data_i.operation;
      s1_val_q    <= s1_val_d;
      s1_quo_q    <= s1_quo_d;
      s1_wk_ok_q  <= s1_wk_ok_d;
      s1_wk_idx_q <= s1_wk_idx_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: pack BCD bytes for encode, and form the Zeller month term and
  // year term. Months 0 to 2 count as months 12 to 14 of the year before.
  // ---------------------------------------------------------------------
  logic [7:0]  s2_res_d [NumBcd];
  logic [7:0]  rem8;
  logic        borrow;
  logic [7:0]  m_eff;
  logic [8:0]  m_plus;
  logic [24:0] m_prod;
  logic [11:0] year_full;
  logic        ge2100, ge2200;
  logic [11:0] s2_yterm_d;

  logic [7:0]  s2_res_q [NumBcd];
  op_e         s2_op_q;
  logic        s2_wk_ok_q;
  logic [2:0]  s2_wk_idx_q;
  logic [7:0]  s2_day_q;
  logic [9:0]  s2_mterm_q;
  logic [11:0] s2_yterm_q;

  always_comb begin
    for (int i = 0; i < NumBcd; i++) begin
      rem8 = s1_val_q[i] - ({3'b0, s1_quo_q[i]} << 3) - ({3'b0, s1_quo_q[i]} << 1);
      s2_res_d[i] = (s1_op_q == OP_ENCODE) ? {s1_quo_q[i][3:0], rem8[3:0]}
                                           : s1_val_q[i];
    end
  end

  // floor(13 * (m + 1) / 5) as one multiply by 13 * 3277 / 16384.
  assign borrow = (s1_val_q[F_MONTH] < 8'd3);
  assign m_eff  = borrow ? s1_val_q[F_MONTH] + 8'd12 : s1_val_q[F_MONTH];
  assign m_plus = {1'b0, m_eff} + 9'd1;
  assign m_prod = 25'(m_plus) * 25'd42601;

  // The year lies between 1999 and 2255, so the century and 400-year
  // corrections reduce to a pair of compares.
  assign year_full  = YearBase + {4'b0, s1_val_q[F_YEAR]} - {11'b0, borrow};
  assign ge2100     = (year_full >= 12'd2100);
  assign ge2200     = (year_full >= 12'd2200);
  assign s2_yterm_d = year_full + (year_full >> 2) - 12'd15
                      - {11'b0, ge2100} - {11'b0, ge2200};

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_op_q     <= s1_op_q;
      s2_res_q    <= s2_res_d;
      s2_wk_ok_q  <= s1_wk_ok_q;
      s2_wk_idx_q <= s1_wk_idx_q;
      s2_day_q    <= s1_val_q[F_DAY];
      s2_mterm_q  <= m_prod[23:14];
      s2_yterm_q  <= s2_yterm_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: Zeller sum, modulo seven by folding octal digits (eight is one
  // modulo seven), weekday selection and the output register.
  // ---------------------------------------------------------------------
  logic [11:0] z_sum;
  logic [4:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  z_h;
  logic [2:0]  z_wday;
  logic [7:0]  wday_byte;
  logic [7:0]  hour_byte;
  rtcc_out_t   out_d, out_q;

  assign z_sum  = s2_yterm_q + {2'b0, s2_mterm_q} + {4'b0, s2_day_q};
  assign fold1  = {2'b0, z_sum[2:0]} + {2'b0, z_sum[5:3]}
                  + {2'b0, z_sum[8:6]} + {2'b0, z_sum[11:9]};
  assign fold2  = {1'b0, fold1[2:0]} + {2'b0, fold1[4:3]};
  assign z_h    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  // Zeller counts from Saturday; shift so that Sunday is zero.
  assign z_wday = (z_h == 3'd0) ? Saturday : z_h - 3'd1;

  always_comb begin
    if (s2_op_q == OP_ENCODE) begin
      wday_byte = week_onehot_q ? (8'd1 << z_wday) : {5'b0, z_wday};
      hour_byte = s2_res_q[F_HOUR] | (hour_flag_q ? HourFlagBit : 8'h00);
    end else begin
      wday_byte = s2_wk_ok_q ? {5'b0, s2_wk_idx_q} : {5'b0, z_wday};
      hour_byte = s2_res_q[F_HOUR];
    end
    out_d.out_second  = s2_res_q[F_SEC];
    out_d.out_minute  = s2_res_q[F_MIN];
    out_d.out_hour    = hour_byte;
    out_d.out_weekday = wday_byte;
    out_d.out_day     = s2_res_q[F_DAY];
    out_d.out_month   = s2_res_q[F_MONTH];
    out_d.out_year    = s2_res_q[F_YEAR];
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/tb_rtc_time_register_codec.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rtc_time_register_codec: random and directed
// decode/encode transactions, checked against an in-bench calendar predictor.
// Depends on rtcc_pkg and the rtc_time_register_codec RTL.

module tb_rtc_time_register_codec;
  import rtcc_pkg::*;

  // Three register stages between acceptance and result.
  localparam int unsigned PipeDepth     = 3;
  localparam int unsigned IdlePercent   = 37;
  localparam int unsigned RandomPerPass = 240;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  cfg_reg_e            cfg_idx_i   = CFG_WEEK_ONEHOT;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  rtcc_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  rtcc_out_t           out_data_o;

  // Shadow copies of the configuration registers, used by the predictor.
  bit week_onehot_q = 1'b0;
  bit hour_flag_q   = 1'b0;
  // While set, neither side inserts idle cycles.
  bit no_idle_q     = 1'b0;

  rtcc_in_t  request_q[$];
  rtcc_out_t converted_q[$];
  int unsigned mismatch_count = 0;

  rtc_time_register_codec u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor.
  // ---------------------------------------------------------------------------

  // A register byte read as tens and units nibbles; nibbles above nine are
  // weighted as they stand, so 0xFF reads as 165.
  function automatic logic [7:0] bcd_value(logic [7:0] b);
    return 8'(int'(b[7:4]) * 10 + int'(b[3:0]));
  endfunction

  // Binary to packed BCD; values above 99 overflow the tens nibble and the
  // result is simply cut to eight bits.
  function automatic logic [7:0] pack_bcd(int unsigned v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // Zeller's congruence for year 2000+yy, folded so that 0 is Sunday.
  // January, February and the out-of-range month 0 belong to the previous
  // year as months 13, 14 and 12.
  function automatic int unsigned zeller_weekday(int unsigned yy, int unsigned month,
                                                 int unsigned day);
    int unsigned y;
    int unsigned m;
    int unsigned h;
    y = yy + 2000;
    m = month;
    if (m < 3) begin
      m += 12;
      y -= 1;
    end
    h = (day + (13 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400) % 7;
    return (h + 6) % 7;
  endfunction

  function automatic rtcc_out_t convert_time(rtcc_in_t it, bit onehot, bit hflag);
    rtcc_out_t   res;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned w;
    logic [7:0]  code;
    if (it.operation == OP_DECODE) begin
      y = 32'(bcd_value(it.in_year));
      m = 32'(bcd_value(it.in_month & MaskMonth));
      d = 32'(bcd_value(it.in_day & MaskHourDay));
      // A one-hot register is valid only with exactly one of bits 0..6 set;
      // bit 7 is ignored. In binary form only the code 7 is invalid.
      w = 7;
      if (onehot) begin
        code = it.in_weekday & 8'h7F;
        for (int i = 0; i < 7; i++) begin
          if (code == 8'(1 << i)) begin
            w = i;
          end
        end
      end else begin
        w = 32'(it.in_weekday[2:0]);
      end
      if (w >= 7) begin
        w = zeller_weekday(y, m, d);
      end
      res.out_second  = bcd_value(it.in_second & MaskSecMin);
      res.out_minute  = bcd_value(it.in_minute & MaskSecMin);
      res.out_hour    = bcd_value(it.in_hour & MaskHourDay);
      res.out_weekday = 8'(w);
      res.out_day     = 8'(d);
      res.out_month   = 8'(m);
      res.out_year    = 8'(y);
    end else begin
      w = zeller_weekday(32'(it.in_year), 32'(it.in_month), 32'(it.in_day));
      res.out_second  = pack_bcd(32'(it.in_second));
      res.out_minute  = pack_bcd(32'(it.in_minute));
      res.out_hour    = pack_bcd(32'(it.in_hour)) | (hflag ? HourFlagBit : 8'h00);
      res.out_weekday = onehot ? 8'(1 << w) : 8'(w);
      res.out_day     = pack_bcd(32'(it.in_day));
      res.out_month   = pack_bcd(32'(it.in_month));
      res.out_year    = pack_bcd(32'(it.in_year));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic rtcc_in_t time_item(op_e op, logic [7:0] s, logic [7:0] mi,
                                         logic [7:0] h, logic [7:0] w, logic [7:0] d,
                                         logic [7:0] mo, logic [7:0] y);
    rtcc_in_t it;
    it.operation  = op;
    it.in_second  = s;
    it.in_minute  = mi;
    it.in_hour    = h;
    it.in_weekday = w;
    it.in_day     = d;
    it.in_month   = mo;
    it.in_year    = y;
    return it;
  endfunction

  // Most transactions are plausible dates and times; a quarter are raw noise
  // that exercises every bit of every field, including non-BCD nibbles.
  function automatic rtcc_in_t random_request();
    rtcc_in_t   it;
    logic [7:0] junk;
    int unsigned pick;
    it = time_item($urandom_range(1) ? OP_ENCODE : OP_DECODE,
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(99) < 25) begin
      return it;
    end
    if (it.operation == OP_ENCODE) begin
      it.in_second = 8'($urandom_range(59));
      it.in_minute = 8'($urandom_range(59));
      it.in_hour   = 8'($urandom_range(23));
      it.in_day    = 8'($urandom_range(31, 1));
      it.in_month  = 8'($urandom_range(12, 1));
      it.in_year   = 8'($urandom_range(99));
    end else begin
      // Bits above each register's mask are sometimes left set; they carry
      // control flags on the chip and must be dropped.
      junk = $urandom_range(3) == 0 ? 8'($urandom) : 8'h00;
      it.in_second = pack_bcd($urandom_range(59)) | (junk & 8'h80);
      it.in_minute = pack_bcd($urandom_range(59)) | (junk & 8'h80);
      it.in_hour   = pack_bcd($urandom_range(23)) | (junk & 8'hC0);
      it.in_day    = pack_bcd($urandom_range(31, 1)) | (junk & 8'hC0);
      it.in_month  = pack_bcd($urandom_range(12, 1)) | (junk & 8'hE0);
      it.in_year   = pack_bcd($urandom_range(99));
      pick = $urandom_range(4);
      case (pick)
        0: begin
          it.in_weekday = 8'(1 << $urandom_range(6)) | (junk & 8'h80);
        end
        1: begin
          it.in_weekday = 8'($urandom_range(6)) | (junk & 8'hF8);
        end
        2: begin
          it.in_weekday = 8'h07 | (junk & 8'hF8);
        end
        default: begin
          it.in_weekday = 8'($urandom);
        end
      endcase
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got 0x%02h, predicted 0x%02h", name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: the input channel. Valid is raised only when a request is waiting
  // and this cycle is not an idle one; once raised it holds, with the same
  // payload, until the transaction is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (request_q.size() != 0 && (no_idle_q || $urandom_range(99) >= IdlePercent)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= request_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts each accepted input transaction, checks each result
  // against the oldest prediction and stalls the output side at random.
  // The result check runs before the push; with a three-stage pipeline a
  // result never belongs to the transaction accepted at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    rtcc_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (converted_q.size() == 0) begin
          flag_mismatch("result transaction with no prediction pending");
        end else begin
          want = converted_q.pop_front();
          compare_field("out_second",  out_data_o.out_second,  want.out_second);
          compare_field("out_minute",  out_data_o.out_minute,  want.out_minute);
          compare_field("out_hour",    out_data_o.out_hour,    want.out_hour);
          compare_field("out_weekday", out_data_o.out_weekday, want.out_weekday);
          compare_field("out_day",     out_data_o.out_day,     want.out_day);
          compare_field("out_month",   out_data_o.out_month,   want.out_month);
          compare_field("out_year",    out_data_o.out_year,    want.out_year);
        end
      end
      if (in_valid_i && in_ready_o) begin
        converted_q.push_back(convert_time(in_data_i, week_onehot_q, hour_flag_q));
      end
      out_ready_i <= no_idle_q || $urandom_range(99) >= IdlePercent;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset, then passes under different configurations. Between
  // passes the bench waits for every result and then idles further so the
  // pipeline is empty before the registers change.
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid_i || converted_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic write_config(cfg_reg_e idx, bit val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WEEK_ONEHOT) begin
      week_onehot_q = val;
    end else begin
      hour_flag_q = val;
    end
  endtask

  task automatic queue_random(int unsigned count);
    for (int i = 0; i < count; i++) begin
      request_q.push_back(random_request());
    end
  endtask

  initial begin
    bit pass_onehot[5];
    bit pass_flag[5];
    pass_onehot = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    pass_flag   = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed decodes under the reset configuration (binary weekday).
    // All zeros: month 0 decodes as 0; weekday code 0 is valid, so Zeller is not used.
    request_q.push_back(time_item(OP_DECODE, 8'h00, 8'h00, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
    // All ones: non-BCD nibbles, year 165, weekday code 7 forces Zeller.
    request_q.push_back(time_item(OP_DECODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                  8'hFF, 8'hFF, 8'hFF));
    request_q.push_back(time_item(OP_DECODE, 8'h59, 8'h59, 8'h23, 8'h03,
                                  8'h31, 8'h12, 8'h99));
    // Leap day with an invalid weekday register: recomputed, February path.
    request_q.push_back(time_item(OP_DECODE, 8'h00, 8'h30, 8'h12, 8'h07,
                                  8'h29, 8'h02, 8'h24));
    // Low three bits are 7 with bit 3 set; January goes to the previous year.
    request_q.push_back(time_item(OP_DECODE, 8'h01, 8'h02, 8'h03, 8'h0F,
                                  8'h01, 8'h01, 8'h00));
    // Valid code 0 with junk in the upper weekday bits.
    request_q.push_back(time_item(OP_DECODE, 8'h10, 8'h20, 8'h08, 8'hF8,
                                  8'h15, 8'h06, 8'h50));
    // Flag bits above each mask must be stripped.
    request_q.push_back(time_item(OP_DECODE, 8'hD9, 8'hB9, 8'hE3, 8'h02,
                                  8'hF1, 8'hF2, 8'h01));
    // Encodes: zeros, largest sane values, overflow, January, February, day 0.
    request_q.push_back(time_item(OP_ENCODE, 8'd0, 8'd0, 8'd0, 8'hFF,
                                  8'd0, 8'd0, 8'd0));
    request_q.push_back(time_item(OP_ENCODE, 8'd59, 8'd59, 8'd23, 8'h00,
                                  8'd31, 8'd12, 8'd99));
    request_q.push_back(time_item(OP_ENCODE, 8'd255, 8'd255, 8'd255, 8'd255,
                                  8'd255, 8'd255, 8'd255));
    request_q.push_back(time_item(OP_ENCODE, 8'd100, 8'd100, 8'd100, 8'h00,
                                  8'd100, 8'd100, 8'd100));
    request_q.push_back(time_item(OP_ENCODE, 8'd30, 8'd45, 8'd6, 8'h00,
                                  8'd1, 8'd1, 8'd0));
    request_q.push_back(time_item(OP_ENCODE, 8'd5, 8'd6, 8'd7, 8'h00,
                                  8'd28, 8'd2, 8'd0));
    request_q.push_back(time_item(OP_ENCODE, 8'd9, 8'd10, 8'd19, 8'h00,
                                  8'd0, 8'd3, 8'd1));

    for (int p = 0; p < 5; p++) begin
      if (p != 0) begin
        wait_drained();
        write_config(CFG_WEEK_ONEHOT, pass_onehot[p]);
        write_config(CFG_HOUR_FLAG, pass_flag[p]);
      end
      // One pass runs with both sides streaming back to back.
      no_idle_q = (p == 2);
      if (p == 1) begin
        // One-hot weekday cases: lowest and highest day, bit 7 ignored,
        // no bit set, two bits set, and an encode in one-hot form.
        request_q.push_back(time_item(OP_DECODE, 8'h00, 8'h00, 8'h00, 8'h01,
                                      8'h01, 8'h01, 8'h25));
        request_q.push_back(time_item(OP_DECODE, 8'h00, 8'h00, 8'h00, 8'h40,
                                      8'h01, 8'h01, 8'h25));
        request_q.push_back(time_item(OP_DECODE, 8'h00, 8'h00, 8'h00, 8'hC0,
                                      8'h14, 8'h07, 8'h25));
        request_q.push_back(time_item(OP_DECODE, 8'h00, 8'h00, 8'h00, 8'h80,
                                      8'h14, 8'h07, 8'h25));
        request_q.push_back(time_item(OP_DECODE, 8'h00, 8'h00, 8'h00, 8'h03,
                                      8'h31, 8'h10, 8'h25));
        request_q.push_back(time_item(OP_DECODE, 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'h31, 8'h10, 8'h25));
        request_q.push_back(time_item(OP_ENCODE, 8'd59, 8'd0, 8'd23, 8'h00,
                                      8'd1, 8'd1, 8'd25));
      end
      queue_random(RandomPerPass);
    end

    wait_drained();
    repeat (PipeDepth * 4) @(posedge clk_i);
    if (converted_q.size() != 0) begin
      flag_mismatch($sformatf("%0d predicted results never arrived", converted_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("rtc_time_register_codec regression: pass");
    end else begin
      $display("rtc_time_register_codec regression: fail");
    end
    $finish;
  end

  // Watchdog: stops a hung run and reports a failure.
  initial begin
    #2_000_000;
    $display("rtc_time_register_codec regression: fail");
    $finish;
  end

endmodule
